// ===== src/metp_pkg.sv =====
// ----------------------------------------------------------------------------
// metp_pkg: shared types and constants for the map entity text parser
// Event and error codes, lexer and grammar states, result record, key word.
// ----------------------------------------------------------------------------
package metp_pkg;

    typedef enum logic [2:0] {
        EV_OPEN        = 3'd0,
        EV_KEY_BYTE    = 3'd1,
        EV_KEY_END     = 3'd2,
        EV_VALUE_BYTE  = 3'd3,
        EV_VALUE_END   = 3'd4,
        EV_CLOSE       = 3'd5,
        EV_FINISH      = 3'd6,
        EV_ERROR       = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_CHAR     = 3'd1,
        ERR_NEED_OPEN    = 3'd2,
        ERR_NEED_KEY     = 3'd3,
        ERR_NEED_VALUE   = 3'd4,
        ERR_TOO_LONG     = 3'd5,
        ERR_TOO_MANY     = 3'd6,
        ERR_UNTERMINATED = 3'd7
    } err_t;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_SLASH   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_OPEN  = 2'd0,
        PH_KEY   = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ENTITIES   = 2'd0;
    localparam logic [1:0] CFG_MAX_STRING_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_KEY_LEN    = 2'd2;

    localparam logic [15:0] RST_MAX_ENTITIES   = 16'd1024;
    localparam logic [15:0] RST_MAX_STRING_LEN = 16'd1023;
    localparam logic [7:0]  RST_MAX_KEY_LEN    = 8'd31;

    localparam logic [15:0] COUNT_SAT = 16'hFFFF;

    // characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_FF     = 8'hFF;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [3:0] CLASS_LEN = 4'd9;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    typedef struct packed {
        event_t      ev;
        logic [7:0]  char_byte;
        logic        has_classname;
        logic [15:0] entity_count;
        err_t        error_code;
        logic        end_of_run;
    } result_t;

    // "classname", one character per position
    function automatic logic [7:0] class_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0: c = 8'h63;
            4'd1: c = 8'h6C;
            4'd2: c = 8'h61;
            4'd3: c = 8'h73;
            4'd4: c = 8'h73;
            4'd5: c = 8'h6E;
            4'd6: c = 8'h61;
            4'd7: c = 8'h6D;
            4'd8: c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic result_t make_result(input event_t ev, input logic [7:0] ch,
                                            input logic cls, input logic [15:0] cnt,
                                            input err_t err);
        result_t r;
        r.ev            = ev;
        r.char_byte     = ch;
        r.has_classname = cls;
        r.entity_count  = cnt;
        r.error_code    = err;
        r.end_of_run    = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/map_entity_text_parser.sv =====
// ----------------------------------------------------------------------------
// map_entity_text_parser: streaming parser for map entity text
// Lexes and parses one text byte per cycle into entity events while s_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the text, one byte per transaction (tdata = byte, tlast marks
//   the final byte). m_* carries events: tuser = event code, tdata holds the
//   string byte, classname flag, closed entity count and error code; tlast
//   marks the last event produced by one input byte.
//   cfg_* writes the three limit registers; write only while the block idles.
//   Each byte is parsed in the cycle it is accepted and its events (zero, one
//   or two) enter a four-entry result queue, whose head is offered on m_*.
//   One byte per cycle is sustained while bytes give at most one event and
//   m_tready stays high; a byte with two events sends them out one at a
//   time through the queue's single read port.
//   s_tready drops while the queue has fewer than two free entries, so a
//   stalled receiver holds the input back without losing events.
//   After a finish or error event, bytes are still accepted but give no
//   events until reset. Reset (aresetn low, synchronous) empties the queue,
//   restores the limit registers to their defaults and the parser state.
// ----------------------------------------------------------------------------
module map_entity_text_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] char_byte, [8] has_classname,
                                    // [24:9] entity_count, [27:25] error_code
    output logic [2:0]  m_tuser,    // [2:0] event_res
    output logic        m_tlast,    // end_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import metp_pkg::*;

    logic [15:0] max_entities_reg;
    logic [15:0] max_string_len_reg;
    logic [7:0]  max_key_len_reg;

    mode_t       mode_reg, mode_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [3:0]  pos_reg, pos_next;
    logic        match_reg, match_next;
    logic        cls_reg, cls_next;
    logic [15:0] closed_reg, closed_next;
    logic        stopped_reg, stopped_next;

    result_t     res_c [2];
    logic [1:0]  n_res;

    result_t     rq_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RQ_AW:0]   count_reg;

    logic       accept;
    logic       pop;
    logic [7:0] b;
    logic       end_byte;
    logic       is_key;
    logic       over;
    result_t    head;

    assign cfg_ready = 1'b1;
    assign b         = s_tdata;
    assign end_byte  = (b == CH_NUL) || (b == CH_FF);
    assign s_tready  = (count_reg <= (RQ_AW+1)'(RQ_DEPTH - 2));
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign pop       = m_tvalid && m_tready;

    always_comb begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        match_next   = match_reg;
        cls_next     = cls_reg;
        closed_next  = closed_reg;
        stopped_next = stopped_reg;
        res_c[0]     = '0;
        res_c[1]     = '0;
        n_res        = 2'd0;
        is_key       = (phase_reg != PH_VALUE);
        over         = 1'b0;

        if (accept && !stopped_reg) begin
            if (!end_byte) begin
                // a lone slash falls back to normal handling of this byte
                if (mode_reg == MODE_SLASH && b != CH_SLASH) begin
                    mode_next = MODE_NORMAL;
                end
                if (mode_reg == MODE_STRING) begin
                    if (b == CH_QUOTE) begin
                        mode_next = MODE_NORMAL;
                        if (is_key) begin
                            if (match_reg && pos_reg == CLASS_LEN) begin
                                cls_next = 1'b1;
                            end
                            res_c[n_res[0]] = make_result(EV_KEY_END, 8'd0, 1'b0,
                                                          closed_next, ERR_NONE);
                            n_res = n_res + 2'd1;
                            phase_next = PH_VALUE;
                        end else begin
                            res_c[n_res[0]] = make_result(EV_VALUE_END, 8'd0, 1'b0,
                                                          closed_next, ERR_NONE);
                            n_res = n_res + 2'd1;
                            phase_next = PH_KEY;
                        end
                    end else if (len_reg >= max_string_len_reg) begin
                        res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                                      closed_next, ERR_TOO_LONG);
                        n_res = n_res + 2'd1;
                        stopped_next = 1'b1;
                    end else begin
                        len_next = len_reg + 16'd1;
                        if (!is_key) begin
                            res_c[n_res[0]] = make_result(EV_VALUE_BYTE, b, 1'b0,
                                                          closed_next, ERR_NONE);
                            n_res = n_res + 2'd1;
                        end else if (len_next <= {8'd0, max_key_len_reg}) begin
                            if (match_reg) begin
                                if (pos_reg < CLASS_LEN && b == class_char(pos_reg)) begin
                                    pos_next = pos_reg + 4'd1;
                                end else begin
                                    match_next = 1'b0;
                                end
                            end
                            res_c[n_res[0]] = make_result(EV_KEY_BYTE, b, 1'b0,
                                                          closed_next, ERR_NONE);
                            n_res = n_res + 2'd1;
                        end
                    end
                end else if (mode_reg == MODE_COMMENT) begin
                    if (b == CH_NL) begin
                        mode_next = MODE_NORMAL;
                    end
                end else if (mode_reg == MODE_SLASH && b == CH_SLASH) begin
                    mode_next = MODE_COMMENT;
                end else begin
                    case (b)
                        CH_NL, CH_CR, CH_TAB, CH_VT, CH_SPACE: begin
                        end
                        CH_HASH, CH_SEMI: begin
                            mode_next = MODE_COMMENT;
                        end
                        CH_SLASH: begin
                            mode_next = MODE_SLASH;
                        end
                        CH_LBRACE: begin
                            if (phase_reg == PH_OPEN) begin
                                res_c[n_res[0]] = make_result(EV_OPEN, 8'd0, 1'b0,
                                                              closed_next, ERR_NONE);
                                n_res = n_res + 2'd1;
                                phase_next = PH_KEY;
                                cls_next   = 1'b0;
                            end else begin
                                res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                    closed_next,
                                    (phase_reg == PH_VALUE) ? ERR_NEED_VALUE : ERR_NEED_KEY);
                                n_res = n_res + 2'd1;
                                stopped_next = 1'b1;
                            end
                        end
                        CH_RBRACE: begin
                            if (phase_reg == PH_OPEN || phase_reg == PH_VALUE) begin
                                res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                    closed_next,
                                    (phase_reg == PH_OPEN) ? ERR_NEED_OPEN : ERR_NEED_VALUE);
                                n_res = n_res + 2'd1;
                                stopped_next = 1'b1;
                            end else begin
                                over = (closed_reg >= max_entities_reg);
                                if (closed_reg != COUNT_SAT) begin
                                    closed_next = closed_reg + 16'd1;
                                end
                                res_c[n_res[0]] = make_result(EV_CLOSE, 8'd0, cls_reg,
                                                              closed_next, ERR_NONE);
                                n_res = n_res + 2'd1;
                                phase_next = PH_OPEN;
                                cls_next   = 1'b0;
                                if (over) begin
                                    res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                                                  closed_next, ERR_TOO_MANY);
                                    n_res = n_res + 2'd1;
                                    stopped_next = 1'b1;
                                end
                            end
                        end
                        CH_QUOTE: begin
                            if (phase_reg == PH_OPEN) begin
                                res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                                              closed_next, ERR_NEED_OPEN);
                                n_res = n_res + 2'd1;
                                stopped_next = 1'b1;
                            end else begin
                                mode_next  = MODE_STRING;
                                len_next   = 16'd0;
                                pos_next   = 4'd0;
                                match_next = 1'b1;
                            end
                        end
                        default: begin
                            res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                                          closed_next, ERR_BAD_CHAR);
                            n_res = n_res + 2'd1;
                            stopped_next = 1'b1;
                        end
                    endcase
                end
            end

            // end of stream: terminator byte, or the flagged last byte
            if (end_byte || (s_tlast && !stopped_next)) begin
                stopped_next = 1'b1;
                if (mode_next == MODE_STRING) begin
                    res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                                  closed_next, ERR_UNTERMINATED);
                end else if (phase_next == PH_OPEN) begin
                    res_c[n_res[0]] = make_result(EV_FINISH, 8'd0, 1'b0,
                                                  closed_next, ERR_NONE);
                end else if (phase_next == PH_VALUE) begin
                    res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                                  closed_next, ERR_NEED_VALUE);
                end else begin
                    res_c[n_res[0]] = make_result(EV_ERROR, 8'd0, 1'b0,
                                                  closed_next, ERR_NEED_KEY);
                end
                n_res = n_res + 2'd1;
            end

            if (n_res != 2'd0) begin
                res_c[n_res[1]].end_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entities_reg   <= RST_MAX_ENTITIES;
            max_string_len_reg <= RST_MAX_STRING_LEN;
            max_key_len_reg    <= RST_MAX_KEY_LEN;
            mode_reg           <= MODE_NORMAL;
            phase_reg          <= PH_OPEN;
            len_reg            <= 16'd0;
            pos_reg            <= 4'd0;
            match_reg          <= 1'b1;
            cls_reg            <= 1'b0;
            closed_reg         <= 16'd0;
            stopped_reg        <= 1'b0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            count_reg          <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_ENTITIES:   max_entities_reg   <= cfg_data;
                    CFG_MAX_STRING_LEN: max_string_len_reg <= cfg_data;
                    CFG_MAX_KEY_LEN:    max_key_len_reg    <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            match_reg   <= match_next;
            cls_reg     <= cls_next;
            closed_reg  <= closed_next;
            stopped_reg <= stopped_next;
            wr_ptr_reg  <= wr_ptr_reg + RQ_AW'(n_res);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
            end
            count_reg <= count_reg + (RQ_AW+1)'(n_res) - (RQ_AW+1)'(pop);
        end
    end

    // result queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            rq_mem[wr_ptr_reg] <= res_c[0];
        end
        if (n_res == 2'd2) begin
            rq_mem[wr_ptr_reg + RQ_AW'(1)] <= res_c[1];
        end
    end

    assign head    = rq_mem[rd_ptr_reg];
    assign m_tuser = head.ev;
    assign m_tdata = {4'd0, head.error_code, head.entity_count,
                      head.has_classname, head.char_byte};
    assign m_tlast = head.end_of_run;

endmodule

// ===== sim/map_entity_text_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// map_entity_text_parser_tb: self-checking bench for the entity text parser
// Streams one long entity text into the parser. Every accepted byte is run
// through a local parser model whose events are queued and compared field by
// field with the events leaving the block. Limit registers are rewritten
// between stretches of traffic while the block is idle. The stream ends on a
// randomly chosen finish or error, followed by bytes that must give nothing.
// ----------------------------------------------------------------------------
module map_entity_text_parser_tb;
    import metp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 16;
    localparam logic [71:0] CLASS_WORD = "classname";

    typedef struct {
        logic [7:0] b;
        logic       last;
    } text_item_t;

    typedef struct {
        event_t      ev;
        logic [7:0]  ch;
        logic        cls;
        logic [15:0] cnt;
        err_t        err;
        logic        eor;
    } event_rec_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;    // [7:0] data_byte
    logic        s_tlast   = 1'b0;     // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;              // [7:0] char_byte, [8] has_classname,
                                       // [24:9] entity_count, [27:25] error_code
    logic [2:0]  m_tuser;              // [2:0] event_res
    logic        m_tlast;              // end_of_run
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_MAX_ENTITIES;
    logic [15:0] cfg_data  = 16'h0000;

    text_item_t text_bytes[$];
    event_rec_t expected_events[$];
    event_rec_t step_events[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_pushed  = 0;
    int mismatches    = 0;
    int cycles        = 0;

    // parser model state and limit registers
    mode_t       lex_mode     = MODE_NORMAL;
    phase_t      phase        = PH_OPEN;
    logic [15:0] str_len      = 16'd0;
    int          match_pos    = 0;
    logic        still_match  = 1'b1;
    logic        cls_seen     = 1'b0;
    logic [15:0] closed_count = 16'd0;
    logic        halted       = 1'b0;
    logic [15:0] lim_entities = RST_MAX_ENTITIES;
    logic [15:0] lim_strlen   = RST_MAX_STRING_LEN;
    logic [7:0]  lim_keylen   = RST_MAX_KEY_LEN;

    map_entity_text_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------- parser model ----------------

    function automatic logic [7:0] word_char(input int pos);
        return CLASS_WORD[71 - 8 * pos -: 8];
    endfunction

    function void emit_event(input event_t ev, input logic [7:0] ch, input logic cls,
                             input err_t err);
        event_rec_t r;
        if (step_events.size() >= 2) return;
        r.ev  = ev;
        r.ch  = ch;
        r.cls = cls;
        r.cnt = closed_count;
        r.err = err;
        r.eor = 1'b0;
        step_events.push_back(r);
    endfunction

    function void abort_parse(input err_t code);
        emit_event(EV_ERROR, 8'h00, 1'b0, code);
        halted = 1'b1;
    endfunction

    function void end_of_text();
        if (lex_mode == MODE_STRING) abort_parse(ERR_UNTERMINATED);
        else if (phase == PH_OPEN) begin
            emit_event(EV_FINISH, 8'h00, 1'b0, ERR_NONE);
            halted = 1'b1;
        end else if (phase == PH_VALUE) abort_parse(ERR_NEED_VALUE);
        else abort_parse(ERR_NEED_KEY);
    endfunction

    function void string_char(input logic [7:0] b);
        logic is_key;
        is_key = (phase != PH_VALUE);
        if (b == CH_QUOTE) begin
            lex_mode = MODE_NORMAL;
            if (is_key) begin
                if (still_match && match_pos == CLASS_LEN) cls_seen = 1'b1;
                emit_event(EV_KEY_END, 8'h00, 1'b0, ERR_NONE);
                phase = PH_VALUE;
            end else begin
                emit_event(EV_VALUE_END, 8'h00, 1'b0, ERR_NONE);
                phase = PH_KEY;
            end
            return;
        end
        if (str_len >= lim_strlen) begin
            abort_parse(ERR_TOO_LONG);
            return;
        end
        str_len = str_len + 16'd1;
        if (!is_key) begin
            emit_event(EV_VALUE_BYTE, b, 1'b0, ERR_NONE);
            return;
        end
        // truncated key bytes count for length only
        if (str_len > {8'h00, lim_keylen}) return;
        if (still_match) begin
            if (match_pos < CLASS_LEN && b == word_char(match_pos)) match_pos++;
            else still_match = 1'b0;
        end
        emit_event(EV_KEY_BYTE, b, 1'b0, ERR_NONE);
    endfunction

    function void structural_char(input logic [7:0] b);
        logic over;
        case (b)
            CH_NL, CH_CR, CH_TAB, CH_VT, CH_SPACE: ;
            CH_HASH, CH_SEMI: lex_mode = MODE_COMMENT;
            CH_SLASH: lex_mode = MODE_SLASH;
            CH_LBRACE: begin
                if (phase == PH_OPEN) begin
                    emit_event(EV_OPEN, 8'h00, 1'b0, ERR_NONE);
                    phase    = PH_KEY;
                    cls_seen = 1'b0;
                end else begin
                    abort_parse(phase == PH_VALUE ? ERR_NEED_VALUE : ERR_NEED_KEY);
                end
            end
            CH_RBRACE: begin
                if (phase == PH_OPEN) abort_parse(ERR_NEED_OPEN);
                else if (phase == PH_VALUE) abort_parse(ERR_NEED_VALUE);
                else begin
                    over = (closed_count >= lim_entities);
                    if (closed_count != COUNT_SAT) closed_count = closed_count + 16'd1;
                    emit_event(EV_CLOSE, 8'h00, cls_seen, ERR_NONE);
                    phase    = PH_OPEN;
                    cls_seen = 1'b0;
                    if (over) abort_parse(ERR_TOO_MANY);
                end
            end
            CH_QUOTE: begin
                if (phase == PH_OPEN) abort_parse(ERR_NEED_OPEN);
                else begin
                    lex_mode    = MODE_STRING;
                    str_len     = 16'd0;
                    match_pos   = 0;
                    still_match = 1'b1;
                end
            end
            default: abort_parse(ERR_BAD_CHAR);
        endcase
    endfunction

    function void parse_text_byte(input logic [7:0] b, input logic last);
        step_events.delete();
        if (halted) return;
        if (b == CH_NUL || b == CH_FF) end_of_text();
        else begin
            case (lex_mode)
                MODE_STRING: string_char(b);
                MODE_COMMENT: if (b == CH_NL) lex_mode = MODE_NORMAL;
                MODE_SLASH: begin
                    if (b == CH_SLASH) lex_mode = MODE_COMMENT;
                    else begin
                        // lone slash dropped, this byte parsed as usual
                        lex_mode = MODE_NORMAL;
                        structural_char(b);
                    end
                end
                default: structural_char(b);
            endcase
            if (last && !halted) end_of_text();
        end
        if (step_events.size() != 0) step_events[step_events.size() - 1].eor = 1'b1;
        foreach (step_events[i]) expected_events.push_back(step_events[i]);
    endfunction

    // ---------------- driver and monitor ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) parse_text_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (text_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_bytes[0].b;
                    s_tlast  <= text_bytes[0].last;
                    void'(text_bytes.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task check_field(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        event_rec_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected event", {29'd0, m_tuser}, 32'd0);
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", 32'(m_tuser), 32'(want.ev));
                    check_field("char_byte", 32'(m_tdata[7:0]), 32'(want.ch));
                    check_field("has_classname", 32'(m_tdata[8]), 32'(want.cls));
                    check_field("entity_count", 32'(m_tdata[24:9]), 32'(want.cnt));
                    check_field("error_code", 32'(m_tdata[27:25]), 32'(want.err));
                    check_field("tdata padding", 32'(m_tdata[31:28]), 32'd0);
                    check_field("end_of_run", 32'(m_tlast), 32'(want.eor));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding", cycles,
                     expected_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    function void put_byte(input logic [7:0] v, input logic l = 1'b0);
        text_item_t t;
        t.b    = v;
        t.last = l;
        text_bytes.push_back(t);
        items_pushed++;
    endfunction

    function automatic logic [7:0] str_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 254)); while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] pick_bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 254));
        while (c inside {CH_NL, CH_CR, CH_TAB, CH_VT, CH_SPACE, CH_HASH, CH_SEMI,
                         CH_SLASH, CH_LBRACE, CH_RBRACE, CH_QUOTE});
        return c;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 4))
            0: return CH_NL;
            1: return CH_CR;
            2: return CH_TAB;
            3: return CH_VT;
            default: return CH_SPACE;
        endcase
    endfunction

    // whitespace and comments, sometimes closed by a lone slash
    function void put_noise();
        int n;
        int m;
        logic [7:0] c;
        n = $urandom_range(0, 3);
        repeat (n) begin
            case ($urandom_range(0, 5))
                3: begin
                    put_byte($urandom_range(0, 1) ? CH_HASH : CH_SEMI);
                    m = $urandom_range(0, 6);
                    repeat (m) begin
                        do c = 8'($urandom_range(1, 254)); while (c == CH_NL);
                        put_byte(c);
                    end
                    put_byte(CH_NL);
                end
                4: begin
                    put_byte(CH_SLASH);
                    put_byte(CH_SLASH);
                    m = $urandom_range(0, 6);
                    repeat (m) begin
                        do c = 8'($urandom_range(1, 254)); while (c == CH_NL);
                        put_byte(c);
                    end
                    put_byte(CH_NL);
                end
                default: put_byte(ws_char());
            endcase
        end
        if ($urandom_range(0, 5) == 0) put_byte(CH_SLASH);
    endfunction

    function void put_string(input logic is_key);
        int n;
        int kind;
        logic drop;
        put_byte(CH_QUOTE);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        if (n > int'(lim_strlen)) n = int'(lim_strlen);
        kind = $urandom_range(0, 4);
        if (is_key && kind <= 1 && lim_strlen >= 16'd10) begin
            // the class key, or a near miss one byte short or long
            drop = 1'($urandom_range(0, 1));
            for (int i = 0; i < 9; i++)
                if (!(kind == 1 && drop && i == 8)) put_byte(word_char(i));
            if (kind == 1 && !drop) put_byte(str_char());
        end else begin
            repeat (n) put_byte(str_char());
        end
        put_byte(CH_QUOTE);
    endfunction

    function void put_entity(input logic last_close);
        int pairs;
        put_noise();
        put_byte(CH_LBRACE);
        put_noise();
        pairs = $urandom_range(0, 3);
        repeat (pairs) begin
            put_string(1'b1);
            put_noise();
            put_string(1'b0);
            put_noise();
        end
        put_byte(CH_RBRACE, last_close);
    endfunction

    task drain();
        while (text_bytes.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_ENTITIES:   lim_entities = val;
            CFG_MAX_STRING_LEN: lim_strlen   = val;
            CFG_MAX_KEY_LEN:    lim_keylen   = val[7:0];
            default: ;
        endcase
    endtask

    task random_stretch(input int count);
        int target;
        target = items_pushed + count;
        while (items_pushed < target) put_entity(1'b0);
        drain();
    endtask

    // ---------------- test sequence ----------------

    initial begin : stimulus
        int n;
        while (!aresetn) @(posedge aclk);
        repeat (2) @(posedge aclk);

        send_idle_pct = 35;
        recv_idle_pct = 71;

        // single entity with an entity limit of one, value bytes at the extremes
        write_reg(CFG_MAX_ENTITIES, 16'd1);
        put_byte(CH_LBRACE);
        put_byte(CH_QUOTE);
        for (int i = 0; i < 9; i++) put_byte(word_char(i));
        put_byte(CH_QUOTE);
        put_byte(CH_SPACE);
        put_byte(CH_QUOTE);
        put_byte(8'h01);
        put_byte(8'hFE);
        put_byte(CH_QUOTE);
        put_byte(CH_RBRACE);
        drain();

        write_reg(CFG_MAX_ENTITIES, 16'hFFFF);
        write_reg(CFG_MAX_STRING_LEN, 16'hFFFF);
        write_reg(CFG_MAX_KEY_LEN, 16'h00FF);

        // comments of both kinds, lone slash before a brace, empty strings
        put_byte(CH_HASH);
        put_byte(8'h78);
        put_byte(CH_NL);
        put_byte(CH_SLASH);
        put_byte(CH_SLASH);
        put_byte(CH_LBRACE);
        put_byte(CH_NL);
        put_byte(CH_SLASH);
        put_byte(CH_LBRACE);
        put_byte(CH_QUOTE);
        put_byte(CH_QUOTE);
        put_byte(CH_TAB);
        put_byte(CH_QUOTE);
        put_byte(CH_QUOTE);
        put_byte(CH_SEMI);
        put_byte(CH_RBRACE);
        put_byte(CH_NL);
        put_byte(CH_CR);
        put_byte(CH_VT);
        put_byte(CH_RBRACE);
        drain();

        random_stretch(170);

        send_idle_pct = 71;
        recv_idle_pct = 35;
        write_reg(CFG_MAX_KEY_LEN, 16'd1);
        write_reg(CFG_MAX_STRING_LEN, 16'd1);
        write_reg(CFG_MAX_ENTITIES, 16'($urandom_range(1000, 65535)));
        random_stretch(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_MAX_STRING_LEN, 16'($urandom_range(10, 64)));
        write_reg(CFG_MAX_KEY_LEN, 16'($urandom_range(8, 12)));
        random_stretch(170);

        // end of the text: one way of finishing or failing
        case ($urandom_range(0, 9))
            0: begin
                put_noise();
                put_byte(CH_NUL);
            end
            1: begin
                put_noise();
                put_byte(CH_FF);
            end
            2: put_entity(1'b1);
            3: begin
                put_noise();
                if ($urandom_range(0, 1)) begin
                    put_byte(CH_LBRACE);
                    put_noise();
                end
                put_byte(pick_bad_char());
            end
            4: begin
                put_noise();
                put_byte($urandom_range(0, 1) ? CH_QUOTE : CH_RBRACE,
                         1'($urandom_range(0, 1)));
            end
            5: begin
                put_byte(CH_LBRACE);
                put_noise();
                if ($urandom_range(0, 1)) begin
                    put_string(1'b1);
                    put_string(1'b0);
                end
                case ($urandom_range(0, 2))
                    0: put_byte(CH_LBRACE);
                    1: put_byte(CH_NUL);
                    default: put_byte(CH_SPACE, 1'b1);
                endcase
            end
            6: begin
                put_byte(CH_LBRACE);
                put_string(1'b1);
                put_noise();
                case ($urandom_range(0, 3))
                    0: put_byte(CH_LBRACE);
                    1: put_byte(CH_RBRACE);
                    2: put_byte(CH_FF);
                    default: put_byte(ws_char(), 1'b1);
                endcase
            end
            7: begin
                n = $urandom_range(1, 5);
                write_reg(CFG_MAX_STRING_LEN, 16'(n));
                put_byte(CH_LBRACE);
                put_byte(CH_QUOTE);
                repeat (n + 1 + $urandom_range(0, 2)) put_byte(str_char());
                put_byte(CH_QUOTE);
            end
            8: begin
                // entity limit reached: close then too-many
                write_reg(CFG_MAX_ENTITIES, closed_count);
                put_entity(1'b0);
            end
            default: begin
                put_byte(CH_LBRACE);
                if ($urandom_range(0, 1)) begin
                    put_string(1'b1);
                    put_noise();
                end
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 4)) put_byte(str_char());
                if ($urandom_range(0, 1)) put_byte(str_char(), 1'b1);
                else put_byte(CH_NUL);
            end
        endcase

        // parser has stopped: anything further must stay silent
        repeat (16) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
